// ===== hdl/edge_list_record_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// edge_list_record_decoder assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef EDGE_LIST_RECORD_DECODER_MACROS_SVH
`define EDGE_LIST_RECORD_DECODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ELRD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("elrd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ELRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("elrd assertion failed");

`endif

// ===== hdl/elrd_pkg.sv =====
// ----------------------------------------------------------------------------
// elrd_pkg
// Types and constants shared by the edge list record decoder modules.
// ----------------------------------------------------------------------------
package elrd_pkg;

  localparam int unsigned WORD_BYTES   = 4;  // count, vertex and neighbour ids
  localparam int unsigned EXTCNT_BYTES = 3;  // extended entry count

  typedef enum logic [2:0] {
    PH_COUNT  = 3'd0,
    PH_VERTEX = 3'd1,
    PH_TYPE   = 3'd2,
    PH_EXTCNT = 3'd3,
    PH_NEIGH  = 3'd4,
    PH_WEIGHT = 3'd5,
    PH_DONE   = 3'd6
  } phase_t;

  typedef struct packed {
    logic [31:0] source_vertex;
    logic [31:0] neighbour_vertex;
    logic [7:0]  edge_weight;
    logic        last_of_vertex;
    logic        last_of_stream;
  } edge_t;

endpackage

// ===== hdl/edge_list_record_decoder.sv =====
// ----------------------------------------------------------------------------
// edge_list_record_decoder
// Decodes a byte stream of adjacency-list records into weighted edges.
// ----------------------------------------------------------------------------
//  channel | signals                                     | handshake
//  --------+---------------------------------------------+-----------------
//  in      | in_byte, stream_start                       | in_valid/in_stall
//  out     | source_vertex, neighbour_vertex, edge_weight,| out_valid/out_stall
//          | last_of_vertex, last_of_stream              |
//
// One byte per cycle sustained unless a weight byte waits behind a stalled
// result. A taken byte sits in the input register and is decoded into the
// result register once the result side is free, and that register drives out.
// Only the weight byte of an entry makes a transaction on out.
// rst is synchronous and returns the parser to expecting a record count.
// in_stall rises only while a weight byte waits behind a stalled result.
// ----------------------------------------------------------------------------
module edge_list_record_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        stream_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] source_vertex,
  output logic [31:0] neighbour_vertex,
  output logic [7:0]  edge_weight,
  output logic        last_of_vertex,
  output logic        last_of_stream
);
  import elrd_pkg::*;

  logic       in_full;
  logic [7:0] byte_r;
  logic       start_r;
  logic       step;
  logic       has_result;
  edge_t      result;
  edge_t      out_edge;

  // a byte with no result never waits on the output side
  assign step     = in_full && (!has_result || !out_valid || !out_stall);
  assign in_stall = in_full && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r  <= in_byte;
      start_r <= stream_start;
    end
  end

  elrd_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .in_byte      (byte_r),
    .stream_start (start_r),
    .has_result   (has_result),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && has_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && has_result) begin
      out_edge <= result;
    end
  end

  assign source_vertex    = out_edge.source_vertex;
  assign neighbour_vertex = out_edge.neighbour_vertex;
  assign edge_weight      = out_edge.edge_weight;
  assign last_of_vertex   = out_edge.last_of_vertex;
  assign last_of_stream   = out_edge.last_of_stream;

endmodule

// ===== hdl/elrd_parser.sv =====
// ----------------------------------------------------------------------------
// elrd_parser
// Parser state and one-byte-per-step decode of the adjacency-list stream.
// ----------------------------------------------------------------------------
module elrd_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic [7:0]     in_byte,
  input  logic           stream_start,
  output logic           has_result,
  output elrd_pkg::edge_t result
);
  import elrd_pkg::*;

  phase_t      phase, phase_next;
  logic [1:0]  byte_index, byte_index_next;
  logic [31:0] records_left, records_left_next;
  logic [31:0] current_vertex, current_vertex_next;
  logic [23:0] entries_left, entries_left_next;
  logic [31:0] field_acc, field_acc_next;

  // state as seen by this byte (stream_start restarts the parser first)
  phase_t      ph;
  logic [1:0]  bi;
  logic [31:0] rl, cv, acc;
  logic [23:0] el;

  logic [31:0] acc_take, rl_dec;
  logic [23:0] el_dec;
  logic [2:0]  pos_inc;
  logic        word_done, ext_done, last_v;

  always_comb begin
    ph  = phase;
    bi  = byte_index;
    rl  = records_left;
    cv  = current_vertex;
    el  = entries_left;
    acc = field_acc;
    if (stream_start) begin
      ph  = PH_COUNT;
      bi  = '0;
      rl  = '0;
      cv  = '0;
      el  = '0;
      acc = '0;
    end

    // little-endian byte merge at the current position
    if (bi == 2'd0) begin
      acc_take = {24'd0, in_byte};
    end else begin
      acc_take = acc | ({24'd0, in_byte} << {bi, 3'b000});
    end
    pos_inc   = {1'b0, bi} + 3'd1;
    word_done = (pos_inc >= 3'(WORD_BYTES));
    ext_done  = (pos_inc >= 3'(EXTCNT_BYTES));
    rl_dec    = rl - 32'd1;
    el_dec    = el - 24'd1;
    last_v    = (el_dec == 24'd0);

    phase_next          = ph;
    byte_index_next     = bi;
    records_left_next   = rl;
    current_vertex_next = cv;
    entries_left_next   = el;
    field_acc_next      = acc;
    has_result          = 1'b0;

    result.source_vertex    = cv;
    result.neighbour_vertex = acc;
    result.edge_weight      = in_byte;
    result.last_of_vertex   = last_v;
    result.last_of_stream   = last_v && (rl_dec == 32'd0);

    unique case (ph)
      PH_COUNT: begin
        field_acc_next = acc_take;
        if (word_done) begin
          byte_index_next   = '0;
          records_left_next = acc_take;
          phase_next        = (acc_take == 32'd0) ? PH_DONE : PH_VERTEX;
        end else begin
          byte_index_next = pos_inc[1:0];
        end
      end
      PH_VERTEX: begin
        field_acc_next = acc_take;
        if (word_done) begin
          byte_index_next     = '0;
          current_vertex_next = acc_take;
          phase_next          = PH_TYPE;
        end else begin
          byte_index_next = pos_inc[1:0];
        end
      end
      PH_TYPE: begin
        byte_index_next = '0;
        if (in_byte != 8'd0) begin
          entries_left_next = {16'd0, in_byte};
          phase_next        = PH_NEIGH;
        end else begin
          phase_next = PH_EXTCNT;
        end
      end
      PH_EXTCNT: begin
        field_acc_next = acc_take;
        if (ext_done) begin
          byte_index_next   = '0;
          entries_left_next = acc_take[23:0];
          if (acc_take[23:0] == 24'd0) begin
            // empty record still counts as finished
            records_left_next = rl_dec;
            phase_next        = (rl_dec == 32'd0) ? PH_DONE : PH_VERTEX;
          end else begin
            phase_next = PH_NEIGH;
          end
        end else begin
          byte_index_next = pos_inc[1:0];
        end
      end
      PH_NEIGH: begin
        field_acc_next = acc_take;
        if (word_done) begin
          byte_index_next = '0;
          phase_next      = PH_WEIGHT;
        end else begin
          byte_index_next = pos_inc[1:0];
        end
      end
      PH_WEIGHT: begin
        has_result        = 1'b1;
        byte_index_next   = '0;
        entries_left_next = el_dec;
        if (last_v) begin
          records_left_next = rl_dec;
          phase_next        = (rl_dec == 32'd0) ? PH_DONE : PH_VERTEX;
        end else begin
          phase_next = PH_NEIGH;
        end
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_COUNT;
      byte_index     <= '0;
      records_left   <= '0;
      current_vertex <= '0;
      entries_left   <= '0;
      field_acc      <= '0;
    end else if (step) begin
      phase          <= phase_next;
      byte_index     <= byte_index_next;
      records_left   <= records_left_next;
      current_vertex <= current_vertex_next;
      entries_left   <= entries_left_next;
      field_acc      <= field_acc_next;
    end
  end

endmodule

// ===== hdl/elrd_checker.sv =====
// ----------------------------------------------------------------------------
// elrd_checker
// Port-level checks for the edge list record decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "edge_list_record_decoder_macros.svh"

module elrd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] source_vertex,
  input logic [31:0] neighbour_vertex,
  input logic [7:0]  edge_weight,
  input logic        last_of_vertex,
  input logic        last_of_stream
);

  logic [73:0] out_payload;

  assign out_payload = {source_vertex, neighbour_vertex, edge_weight,
                        last_of_vertex, last_of_stream};

  // input backpressure only comes from a stalled result
  `ELRD_ASSERT_NOW(a_stall_from_out, in_stall, out_valid && out_stall)

  // end of stream is always end of a record
  `ELRD_ASSERT_NOW(a_last_nesting, out_valid && last_of_stream, last_of_vertex)

  // a stalled result transaction holds
  `ELRD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_payload))

  // a stalled input transaction stays offered
  `ELRD_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid)

endmodule

bind edge_list_record_decoder elrd_checker u_elrd_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .source_vertex    (source_vertex),
  .neighbour_vertex (neighbour_vertex),
  .edge_weight      (edge_weight),
  .last_of_vertex   (last_of_vertex),
  .last_of_stream   (last_of_stream)
);

// ===== dv/edge_list_record_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// edge_list_record_decoder_tb
// Self-checking bench for the edge list decoder. Byte streams of records are
// driven over valid/stall with random gaps and back-pressure. A scoreboard
// class tracks the parser state, predicts each edge and checks edges in order.
// ----------------------------------------------------------------------------
module edge_list_record_decoder_tb;
  import elrd_pkg::*;

  localparam int unsigned TARGET_BYTES = 1050;  // input bytes over all phases
  localparam int unsigned NUM_PHASES   = 4;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned MAX_EMITTED  = 6;     // most entries generated per record

  class edge_scoreboard;
    phase_t      phase;
    logic [1:0]  byte_pos;
    logic [31:0] records_left;
    logic [31:0] vertex;
    logic [23:0] entries_left;
    logic [31:0] acc;
    edge_t       expected_edges[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned stream_ends;

    function new();
      restart();
      mismatches  = 0;
      checked     = 0;
      stream_ends = 0;
    endfunction

    function void restart();
      phase        = PH_COUNT;
      byte_pos     = 2'd0;
      records_left = 32'd0;
      vertex       = 32'd0;
      entries_left = 24'd0;
      acc          = 32'd0;
    endfunction

    // little-endian field assembly; 1 when the field is complete
    function bit take_field_byte(logic [7:0] b, int unsigned nbytes);
      if (byte_pos == 2'd0) acc = {24'd0, b};
      else acc = acc | ({24'd0, b} << (8 * byte_pos));
      if (byte_pos + 1 >= nbytes) begin
        byte_pos = 2'd0;
        return 1'b1;
      end
      byte_pos = byte_pos + 2'd1;
      return 1'b0;
    endfunction

    function void end_record();
      records_left = records_left - 32'd1;
      phase = (records_left == 32'd0) ? PH_DONE : PH_VERTEX;
    endfunction

    // notes one accepted input transaction; 1 when the byte was not ignored
    function bit note_input(logic [7:0] b, logic start);
      bit    decoded;
      bit    last_v;
      bit    last_s;
      edge_t exp_edge;
      if (start) restart();
      decoded = (phase != PH_DONE);
      case (phase)
        PH_COUNT: begin
          if (take_field_byte(b, WORD_BYTES)) begin
            records_left = acc;
            phase = (acc == 32'd0) ? PH_DONE : PH_VERTEX;
          end
        end
        PH_VERTEX: begin
          if (take_field_byte(b, WORD_BYTES)) begin
            vertex = acc;
            phase  = PH_TYPE;
          end
        end
        PH_TYPE: begin
          byte_pos = 2'd0;
          if (b != 8'd0) begin
            entries_left = {16'd0, b};
            phase = PH_NEIGH;
          end else begin
            phase = PH_EXTCNT;
          end
        end
        PH_EXTCNT: begin
          if (take_field_byte(b, EXTCNT_BYTES)) begin
            entries_left = acc[23:0];
            if (entries_left == 24'd0) end_record();
            else phase = PH_NEIGH;
          end
        end
        PH_NEIGH: begin
          if (take_field_byte(b, WORD_BYTES)) phase = PH_WEIGHT;
        end
        PH_WEIGHT: begin
          entries_left = entries_left - 24'd1;
          last_v = (entries_left == 24'd0);
          last_s = 1'b0;
          if (last_v) begin
            end_record();
            last_s = (records_left == 32'd0);
          end else begin
            phase = PH_NEIGH;
          end
          byte_pos = 2'd0;
          exp_edge = '{source_vertex: vertex, neighbour_vertex: acc,
                       edge_weight: b, last_of_vertex: last_v,
                       last_of_stream: last_s};
          expected_edges.insert(expected_edges.size(), exp_edge);
        end
        default: phase = PH_DONE;
      endcase
      return decoded;
    endfunction

    function void check_edge(edge_t got);
      edge_t want;
      if (expected_edges.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected edge src=%h nbr=%h w=%h lv=%b ls=%b",
                   got.source_vertex, got.neighbour_vertex, got.edge_weight,
                   got.last_of_vertex, got.last_of_stream);
        return;
      end
      want = expected_edges.pop_front();
      checked++;
      if (want.last_of_stream) stream_ends++;
      if (got.source_vertex !== want.source_vertex ||
          got.neighbour_vertex !== want.neighbour_vertex ||
          got.edge_weight !== want.edge_weight ||
          got.last_of_vertex !== want.last_of_vertex ||
          got.last_of_stream !== want.last_of_stream) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("ERROR: edge %0d expected src=%h nbr=%h w=%h lv=%b ls=%b", checked,
                   want.source_vertex, want.neighbour_vertex, want.edge_weight,
                   want.last_of_vertex, want.last_of_stream);
          $display("       edge %0d actual   src=%h nbr=%h w=%h lv=%b ls=%b", checked,
                   got.source_vertex, got.neighbour_vertex, got.edge_weight,
                   got.last_of_vertex, got.last_of_stream);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_edges.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        stream_start;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] source_vertex;
  logic [31:0] neighbour_vertex;
  logic [7:0]  edge_weight;
  logic        last_of_vertex;
  logic        last_of_stream;

  edge_scoreboard sb = new();

  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned hold_requests;
  int unsigned bytes_sent;
  int unsigned decoded_bytes;
  int unsigned streams_sent;

  edge_list_record_decoder u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .stream_start     (stream_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .source_vertex    (source_vertex),
    .neighbour_vertex (neighbour_vertex),
    .edge_weight      (edge_weight),
    .last_of_vertex   (last_of_vertex),
    .last_of_stream   (last_of_stream)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void append_byte(ref logic [7:0] q[$], input logic [7:0] b);
    q.insert(q.size(), b);
  endfunction

  function automatic void push_le(ref logic [7:0] q[$], input logic [31:0] v,
                                  input int unsigned nbytes);
    for (int unsigned i = 0; i < nbytes; i++) append_byte(q, v[8*i +: 8]);
  endfunction

  task automatic drive_byte(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_byte      <= b;
    stream_start <= start;
    do @(posedge clk); while (in_stall);
    if (sb.note_input(b, start)) decoded_bytes++;
    bytes_sent++;
  endtask

  // start flag goes with the first byte only
  task automatic send_bytes(ref logic [7:0] q[$], input logic start);
    for (int unsigned i = 0; i < q.size(); i++) drive_byte(q[i], start && (i == 0));
    streams_sent++;
  endtask

  task automatic send_directed();
    logic [7:0] q[$];
    // bytes ahead of any stream_start are parsed: two records, the second
    // with a zero extended count, then a trailing byte that is ignored
    push_le(q, 32'd2, WORD_BYTES);
    push_le(q, 32'hFFFF_FFFF, WORD_BYTES);
    append_byte(q, 8'h01);
    push_le(q, 32'hFFFF_FFFF, WORD_BYTES);
    append_byte(q, 8'hFF);
    push_le(q, 32'h0000_0000, WORD_BYTES);
    append_byte(q, 8'h00);
    push_le(q, 32'd0, EXTCNT_BYTES);
    append_byte(q, 8'hAA);
    send_bytes(q, 1'b0);
    // partial stream cut by a restart
    q.delete();
    push_le(q, 32'd2, WORD_BYTES);
    append_byte(q, 8'h67);
    append_byte(q, 8'h45);
    send_bytes(q, 1'b1);
    // zero record count, then an ignored byte
    q.delete();
    push_le(q, 32'd0, WORD_BYTES);
    append_byte(q, 8'hFF);
    send_bytes(q, 1'b1);
  endtask

  task automatic send_random_stream();
    logic [7:0]  q[$];
    logic [31:0] count_word;
    int unsigned num_records;
    int unsigned num_entries;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) begin
      // raw noise behind a stream_start
      repeat ($urandom_range(1, 12)) append_byte(q, 8'($urandom_range(0, 255)));
    end else begin
      r = $urandom_range(99);
      if (r < 8) count_word = 32'd0;
      else if (r < 14) count_word = $urandom;
      else count_word = $urandom_range(1, 3);
      push_le(q, count_word, WORD_BYTES);
      num_records = (count_word > 4) ? $urandom_range(1, 3) : count_word;
      for (int unsigned i = 0; i < num_records; i++) begin
        push_le(q, $urandom, WORD_BYTES);
        r = $urandom_range(99);
        if (r < 70) begin
          num_entries = $urandom_range(1, 4);
          append_byte(q, 8'(num_entries));
        end else if (r < 80) begin
          num_entries = $urandom_range(5, 255);
          append_byte(q, 8'(num_entries));
        end else begin
          num_entries = ($urandom_range(99) < 80) ? $urandom_range(0, 3)
                                                  : $urandom_range(0, 24'hFF_FFFF);
          append_byte(q, 8'h00);
          push_le(q, num_entries, EXTCNT_BYTES);
        end
        for (int unsigned e = 0; e < num_entries && e < MAX_EMITTED; e++) begin
          push_le(q, $urandom, WORD_BYTES);
          append_byte(q, 8'($urandom_range(0, 255)));
        end
        // long record left open; the next stream_start restarts the parser
        if (num_entries > MAX_EMITTED) break;
      end
      if ($urandom_range(99) < 10) begin
        r = $urandom_range(1, q.size());
        while (q.size() > r) void'(q.pop_back());
      end
      repeat ($urandom_range(0, 3)) append_byte(q, 8'($urandom_range(0, 255)));
    end
    send_bytes(q, 1'b1);
  endtask

  // result side: checks each transaction, random stall, long hold on request
  initial begin
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        sb.check_edge('{source_vertex: source_vertex, neighbour_vertex: neighbour_vertex,
                        edge_weight: edge_weight, last_of_vertex: last_of_vertex,
                        last_of_stream: last_of_stream});
      if (hold_left == 0 && holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("ERROR: no transaction for %0d cycles", QUIET_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int unsigned tx_pct[NUM_PHASES];
    int unsigned rx_pct[NUM_PHASES];
    tx_pct = '{0, 83, 0, 19};
    rx_pct = '{0, 0, 83, 19};
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    hold_requests = 0;
    bytes_sent    = 0;
    decoded_bytes = 0;
    streams_sent  = 0;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    in_byte      <= 8'd0;
    stream_start <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_directed();
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      tx_idle_pct  = tx_pct[p];
      rx_stall_pct = rx_pct[p];
      // sender keeps offering bytes while the result side is held off
      if (p == 0) hold_requests++;
      while (bytes_sent < (p + 1) * TARGET_BYTES / NUM_PHASES) send_random_stream();
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes (%0d decoded) in %0d streams over four gap/stall phases",
             bytes_sent, decoded_bytes, streams_sent);
    $display("Checked %0d edges, %0d closing a stream", sb.checked, sb.stream_ends);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d edges outstanding", sb.mismatches, sb.pending());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/elrd_pkg.sv
hdl/elrd_parser.sv
hdl/edge_list_record_decoder.sv
hdl/elrd_checker.sv
dv/edge_list_record_decoder_tb.sv
